>>> src/pis_pkg.sv
// ----------------------------------------------------------------------------
// pis_pkg
// Shared constants, codes and types for the point-in-shape test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pis_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    // multiplier limb width and fixed multiplier latency
    localparam int LIMB_W  = 32;
    localparam int MUL_LAT = 3;

    localparam int CFG_IDX_W = 3;
    localparam int SHAPE_W   = 3;

    // configuration register indices
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_KIND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_HIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_LOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_Z_HIGH     = 3'd6;

    // shape codes
    localparam logic [SHAPE_W-1:0] SHAPE_BOX       = 3'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_ELLIPSOID = 3'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_CYL_Z     = 3'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_CYL_X     = 3'd3;
    localparam logic [SHAPE_W-1:0] SHAPE_CYL_Y     = 3'd4;

    // request codes
    localparam logic REQ_XY  = 1'b0;
    localparam logic REQ_XYZ = 1'b1;

    // per-item decision flags carried alongside the arithmetic
    typedef struct packed {
        logic use_ell;
        logic base_ok;
    } pis_flags_t;

endpackage

`default_nettype wire

>>> src/pis_mul.sv
// ----------------------------------------------------------------------------
// pis_mul
// Unsigned pipelined multiplier: limb partial products, row sums, final sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pis_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  wire logic               aclk,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic      [A_W+B_W-1:0] p
);

    localparam int LW = pis_pkg::LIMB_W;
    localparam int NA = (A_W + LW - 1) / LW;
    localparam int NB = (B_W + LW - 1) / LW;
    localparam int RW = (NA + 1) * LW;
    localparam int FW = (NA + NB) * LW;

    logic [NA*LW-1:0] a_ext;
    logic [NB*LW-1:0] b_ext;

    logic [2*LW-1:0]    pp_next  [NA][NB];
    logic [2*LW-1:0]    pp_reg   [NA][NB];
    logic [RW-1:0]      row_next [NB];
    logic [RW-1:0]      row_reg  [NB];
    logic [FW-1:0]      sum_next;
    logic [A_W+B_W-1:0] p_reg;

    assign a_ext = (NA*LW)'(a);
    assign b_ext = (NB*LW)'(b);

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                pp_next[i][j] = a_ext[i*LW +: LW] * b_ext[j*LW +: LW];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NB; j++) begin
            row_next[j] = '0;
            for (int i = 0; i < NA; i++) begin
                row_next[j] = row_next[j] + (RW'(pp_reg[i][j]) << (i*LW));
            end
        end
    end

    always_comb begin
        sum_next = '0;
        for (int j = 0; j < NB; j++) begin
            sum_next = sum_next + (FW'(row_reg[j]) << (j*LW));
        end
    end

    always_ff @(posedge aclk) begin
        pp_reg  <= pp_next;
        row_reg <= row_next;
        p_reg   <= sum_next[A_W+B_W-1:0];
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> src/pis_dly.sv
// ----------------------------------------------------------------------------
// pis_dly
// Fixed-length delay line aligning side data with the multiplier levels.
// ----------------------------------------------------------------------------
`default_nettype none

module pis_dly #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1
) (
    input  wire logic              aclk,
    input  wire logic [DATA_W-1:0] din,
    output logic      [DATA_W-1:0] dout
);

    logic [DATA_W-1:0] stage_reg [DEPTH];

    always_ff @(posedge aclk) begin
        stage_reg[0] <= din;
        for (int k = 1; k < DEPTH; k++) begin
            stage_reg[k] <= stage_reg[k-1];
        end
    end

    assign dout = stage_reg[DEPTH-1];

endmodule

`default_nettype wire

>>> src/point_in_shape_test.sv
// ----------------------------------------------------------------------------
// point_in_shape_test
// Each point passes stage 1, the multiplier levels and the sum registers.
// Throughput: one point per cycle while s_ready, via three pipelined mul levels.
// A 16-entry result queue decouples the pipeline; input stalls once 16 items
// are in flight or queued.
// Reset (aresetn low, synchronous) zeroes config, valid bits and queue pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_shape_test #(
    parameter int COORD_WIDTH = pis_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            cfg_wr_en,
    input  wire logic [pis_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [COORD_WIDTH-1:0]          cfg_wdata,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_req_type,
    input  wire logic signed [COORD_WIDTH-1:0]   s_point_x,
    input  wire logic signed [COORD_WIDTH-1:0]   s_point_y,
    input  wire logic signed [COORD_WIDTH-1:0]   s_point_z,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_inside_res
);

    localparam int W          = COORD_WIDTH;
    localparam int DW         = W + 2;
    localparam int R2_W       = 2 * W;
    localparam int P_W        = DW + R2_W;
    localparam int Q_W        = W + R2_W;
    localparam int P2_W       = 2 * P_W;
    localparam int Q2_W       = 2 * Q_W;
    localparam int SUM_W      = P2_W + 2;
    localparam int ML         = pis_pkg::MUL_LAT;
    localparam int PIPE_DEPTH = 3 * ML + 3;
    localparam int FL_W       = $bits(pis_pkg::pis_flags_t);
    localparam int FIFO_AW    = $clog2(PIPE_DEPTH + 2);
    localparam int FIFO_D     = 1 << FIFO_AW;

    // configuration
    logic [pis_pkg::SHAPE_W-1:0] shape_reg;
    logic signed [W-1:0]         lo_reg [3];
    logic signed [W-1:0]         hi_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg <= pis_pkg::SHAPE_BOX;
            for (int k = 0; k < 3; k++) begin
                lo_reg[k] <= '0;
                hi_reg[k] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pis_pkg::REG_SHAPE_KIND: shape_reg <= cfg_wdata[pis_pkg::SHAPE_W-1:0];
                pis_pkg::REG_X_LOW:      lo_reg[0] <= cfg_wdata;
                pis_pkg::REG_X_HIGH:     hi_reg[0] <= cfg_wdata;
                pis_pkg::REG_Y_LOW:      lo_reg[1] <= cfg_wdata;
                pis_pkg::REG_Y_HIGH:     hi_reg[1] <= cfg_wdata;
                pis_pkg::REG_Z_LOW:      lo_reg[2] <= cfg_wdata;
                pis_pkg::REG_Z_HIGH:     hi_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // handshake
    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;

    // front end: doubled offsets, extents, range checks
    logic signed [W-1:0] pt [3];
    logic [2:0]          in_rng;
    logic [2:0]          ext_pos;
    logic [W-1:0]        ext [3];
    logic [DW-1:0]       mag [3];

    assign pt[0] = s_point_x;
    assign pt[1] = s_point_y;
    assign pt[2] = s_point_z;

    for (genvar g = 0; g < 3; g++) begin : g_axis
        logic signed [DW-1:0] off;

        assign in_rng[g]  = (pt[g] >= lo_reg[g]) && (pt[g] <= hi_reg[g]);
        assign ext_pos[g] = hi_reg[g] > lo_reg[g];
        assign ext[g]     = hi_reg[g] - lo_reg[g];
        assign off        = {pt[g][W-1], pt[g], 1'b0}
                          - {{2{lo_reg[g][W-1]}}, lo_reg[g]}
                          - {{2{hi_reg[g][W-1]}}, hi_reg[g]};
        assign mag[g]     = off[DW-1] ? -off : off;
    end

    logic [2:0]          use_ax;
    pis_pkg::pis_flags_t flg_next;

    always_comb begin
        use_ax           = 3'b000;
        flg_next.use_ell = 1'b0;
        flg_next.base_ok = 1'b0;
        if (s_req_type == pis_pkg::REQ_XY) begin
            case (shape_reg)
                pis_pkg::SHAPE_BOX: begin
                    flg_next.base_ok = in_rng[0] && in_rng[1];
                end
                pis_pkg::SHAPE_ELLIPSOID, pis_pkg::SHAPE_CYL_Z: begin
                    use_ax           = 3'b011;
                    flg_next.use_ell = 1'b1;
                    flg_next.base_ok = ext_pos[0] && ext_pos[1];
                end
                pis_pkg::SHAPE_CYL_X: begin
                    flg_next.base_ok = in_rng[1];
                end
                pis_pkg::SHAPE_CYL_Y: begin
                    flg_next.base_ok = in_rng[0];
                end
                default: ;
            endcase
        end else begin
            case (shape_reg)
                pis_pkg::SHAPE_BOX: begin
                    flg_next.base_ok = in_rng[2] && in_rng[0] && in_rng[1];
                end
                pis_pkg::SHAPE_ELLIPSOID: begin
                    use_ax           = 3'b111;
                    flg_next.use_ell = 1'b1;
                    flg_next.base_ok = in_rng[2] && (&ext_pos);
                end
                pis_pkg::SHAPE_CYL_Z: begin
                    use_ax           = 3'b011;
                    flg_next.use_ell = 1'b1;
                    flg_next.base_ok = in_rng[2] && ext_pos[0] && ext_pos[1];
                end
                pis_pkg::SHAPE_CYL_X: begin
                    use_ax           = 3'b110;
                    flg_next.use_ell = 1'b1;
                    flg_next.base_ok = in_rng[2] && in_rng[0] && ext_pos[1] && ext_pos[2];
                end
                pis_pkg::SHAPE_CYL_Y: begin
                    use_ax           = 3'b101;
                    flg_next.use_ell = 1'b1;
                    flg_next.base_ok = in_rng[2] && in_rng[1] && ext_pos[0] && ext_pos[2];
                end
                default: ;
            endcase
        end
    end

    // stage 1: unused axes become D = 0, R = 1
    logic [DW-1:0]       dm_reg [3];
    logic [W-1:0]        rr_reg [3];
    pis_pkg::pis_flags_t flg_reg;

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            dm_reg[k] <= use_ax[k] ? mag[k] : '0;
            rr_reg[k] <= use_ax[k] ? ext[k] : W'(1);
        end
        flg_reg <= flg_next;
    end

    // valid bits
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;

    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], in_xfer};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // level 1: pairwise extent products
    logic [R2_W-1:0] ryz, rxz, rxy;

    pis_mul #(.A_W(W), .B_W(W)) u_mul_ryz (.aclk(aclk), .a(rr_reg[1]), .b(rr_reg[2]), .p(ryz));
    pis_mul #(.A_W(W), .B_W(W)) u_mul_rxz (.aclk(aclk), .a(rr_reg[0]), .b(rr_reg[2]), .p(rxz));
    pis_mul #(.A_W(W), .B_W(W)) u_mul_rxy (.aclk(aclk), .a(rr_reg[0]), .b(rr_reg[1]), .p(rxy));

    logic [3*DW-1:0] dm_d;
    logic [W-1:0]    rx_d;

    pis_dly #(.DATA_W(3*DW), .DEPTH(ML)) u_dly_dm (
        .aclk(aclk),
        .din ({dm_reg[2], dm_reg[1], dm_reg[0]}),
        .dout(dm_d)
    );

    pis_dly #(.DATA_W(W), .DEPTH(ML)) u_dly_rx (
        .aclk(aclk),
        .din (rr_reg[0]),
        .dout(rx_d)
    );

    // level 2: scaled offsets and full extent product
    logic [P_W-1:0] px, py, pz;
    logic [Q_W-1:0] q;

    pis_mul #(.A_W(DW), .B_W(R2_W)) u_mul_px (
        .aclk(aclk), .a(dm_d[0*DW +: DW]), .b(ryz), .p(px));
    pis_mul #(.A_W(DW), .B_W(R2_W)) u_mul_py (
        .aclk(aclk), .a(dm_d[1*DW +: DW]), .b(rxz), .p(py));
    pis_mul #(.A_W(DW), .B_W(R2_W)) u_mul_pz (
        .aclk(aclk), .a(dm_d[2*DW +: DW]), .b(rxy), .p(pz));
    pis_mul #(.A_W(W), .B_W(R2_W)) u_mul_q (
        .aclk(aclk), .a(rx_d), .b(ryz), .p(q));

    // level 3: squares
    logic [P2_W-1:0] px2, py2, pz2;
    logic [Q2_W-1:0] q2;

    pis_mul #(.A_W(P_W), .B_W(P_W)) u_sq_px (.aclk(aclk), .a(px), .b(px), .p(px2));
    pis_mul #(.A_W(P_W), .B_W(P_W)) u_sq_py (.aclk(aclk), .a(py), .b(py), .p(py2));
    pis_mul #(.A_W(P_W), .B_W(P_W)) u_sq_pz (.aclk(aclk), .a(pz), .b(pz), .p(pz2));
    pis_mul #(.A_W(Q_W), .B_W(Q_W)) u_sq_q  (.aclk(aclk), .a(q),  .b(q),  .p(q2));

    // sum and compare
    logic [SUM_W-1:0] sxy_reg;
    logic [P2_W-1:0]  pz2_reg;
    logic [Q2_W-1:0]  q2_a_reg;
    logic [SUM_W-1:0] tot_reg;
    logic [Q2_W-1:0]  q2_b_reg;

    always_ff @(posedge aclk) begin
        sxy_reg  <= SUM_W'(px2) + SUM_W'(py2);
        pz2_reg  <= pz2;
        q2_a_reg <= q2;
        tot_reg  <= sxy_reg + SUM_W'(pz2_reg);
        q2_b_reg <= q2_a_reg;
    end

    logic [FL_W-1:0]     flg_d_bits;
    pis_pkg::pis_flags_t flg_d;
    logic                ell_ok;
    logic                hit;

    pis_dly #(.DATA_W(FL_W), .DEPTH(PIPE_DEPTH-1)) u_dly_flg (
        .aclk(aclk),
        .din (flg_reg),
        .dout(flg_d_bits)
    );

    assign flg_d  = pis_pkg::pis_flags_t'(flg_d_bits);
    assign ell_ok = tot_reg <= SUM_W'(q2_b_reg);
    assign hit    = flg_d.base_ok && (!flg_d.use_ell || ell_ok);

    // result queue, sized for every item in flight
    logic [FIFO_D-1:0]  fifo_reg;
    logic [FIFO_AW:0]   wr_ptr_reg;
    logic [FIFO_AW:0]   rd_ptr_reg;
    logic [FIFO_AW:0]   cnt_reg;
    logic [FIFO_AW:0]   cnt_next;

    always_ff @(posedge aclk) begin
        if (vld_reg[PIPE_DEPTH-1]) begin
            fifo_reg[wr_ptr_reg[FIFO_AW-1:0]] <= hit;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (in_xfer && !out_xfer) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!in_xfer && out_xfer) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (vld_reg[PIPE_DEPTH-1]) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_xfer) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    assign s_ready      = !cnt_reg[FIFO_AW];
    assign m_valid      = wr_ptr_reg != rd_ptr_reg;
    assign m_inside_res = fifo_reg[rd_ptr_reg[FIFO_AW-1:0]];

endmodule

`default_nettype wire
